// ===== rtl/nfa_accepting_path_counter_macros.svh =====
// Assertion helpers shared by the block's modules.
// NAPC_ASSERT checks on every clock edge outside reset.
// NAPC_ASSERT_ALWAYS also checks while reset is asserted.
`ifndef NFA_ACCEPTING_PATH_COUNTER_MACROS_SVH
`define NFA_ACCEPTING_PATH_COUNTER_MACROS_SVH
`ifndef SYNTHESIS
`define NAPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NAPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define NAPC_ASSERT(lbl, prop, msg)
`define NAPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/napc_pkg.sv =====
`default_nettype none

package napc_pkg;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned STATE_W    = 4;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned PCOUNT_W   = 32;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_START  = 2'd1,
    KIND_SYMBOL = 2'd2,
    KIND_FINISH = 2'd3
  } napc_kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COPY,
    ST_SUM,
    ST_EMIT
  } napc_state_e;

  // One transition table slot, 17 bits.
  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] to;
    logic [SYM_W-1:0]   sym;
    logic [STATE_W-1:0] from;
  } napc_entry_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic start;
    logic sym_begin;
    logic scan_rd;
    logic copy;
    logic fin_begin;
    logic sum_step;
    logic emit;
  } napc_cmd_t;

  typedef struct packed {
    logic tab_last;
    logic fin_last;
    logic out_free;
  } napc_stat_t;

endpackage

`default_nettype wire

// ===== rtl/napc_ram.sv =====
`default_nettype none

module napc_ram #(
  parameter int unsigned WIDTH  = 17,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/napc_ctrl.sv =====
`default_nettype none
`include "nfa_accepting_path_counter_macros.svh"

module napc_ctrl
  import napc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [KIND_W-1:0] in_kind_i,
  output logic                   in_ready_o,
  input  wire napc_stat_t        stat_i,
  output napc_cmd_t              cmd_o
);

  napc_state_e state_q, state_d;
  napc_kind_e  kind;

  assign kind = napc_kind_e'(in_kind_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.tab_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (kind)
            KIND_LOAD:   cmd_o.load = 1'b1;
            KIND_START:  cmd_o.start = 1'b1;
            KIND_SYMBOL: begin
              cmd_o.sym_begin = 1'b1;
              state_d         = ST_SCAN;
            end
            KIND_FINISH: begin
              cmd_o.fin_begin = 1'b1;
              state_d         = ST_SUM;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.tab_last) begin
          state_d = ST_DRAIN;
        end
      end
      // last table entry is folded in during this cycle
      ST_DRAIN: state_d = ST_COPY;
      ST_COPY: begin
        cmd_o.copy = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (stat_i.fin_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  `NAPC_ASSERT(a_emit_hold, (state_q == ST_EMIT && !stat_i.out_free) |=> state_q == ST_EMIT,
               "result dropped while output register busy")
  `NAPC_ASSERT(a_scan_end, (state_q == ST_SCAN && stat_i.tab_last) |=> state_q == ST_DRAIN,
               "table scan did not drain")
  `NAPC_ASSERT(a_emit_free, cmd_o.emit |-> stat_i.out_free,
               "emit into occupied output register")

endmodule

`default_nettype wire

// ===== rtl/napc_dp.sv =====
`default_nettype none
`include "nfa_accepting_path_counter_macros.svh"

module napc_dp
  import napc_pkg::*;
#(
  parameter int unsigned NUM_STATES      = 16,
  parameter int unsigned MAX_TRANSITIONS = 64,
  parameter int unsigned COUNT_WIDTH     = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire napc_cmd_t             cmd_i,
  output napc_stat_t                 stat_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  input  wire logic                  m_tready_i,
  output logic                       m_tvalid_o,
  output logic      [OUT_DATA_W-1:0] m_tdata_o
);

  localparam int unsigned AW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int unsigned IW = (AW > IDX_W) ? AW : IDX_W;
  localparam int unsigned SW = $clog2(NUM_STATES);
  localparam int unsigned XW = (SW > STATE_W) ? SW : STATE_W;
  localparam int unsigned NF = (NUM_STATES < 16) ? NUM_STATES : 16;
  localparam int unsigned EW = $bits(napc_entry_t);

  // input item fields
  logic [IDX_W-1:0]   in_idx;
  logic [STATE_W-1:0] in_from;
  logic [SYM_W-1:0]   in_sym;
  logic [STATE_W-1:0] in_to;
  logic               in_ev;

  assign in_idx  = in_data_i[5:0];
  assign in_from = in_data_i[9:6];
  assign in_sym  = in_data_i[17:10];
  assign in_to   = in_data_i[21:18];
  assign in_ev   = in_data_i[22];

  logic [STATE_W-1:0]   start_q;
  logic [CFG_W-1:0]     fmask_q;
  logic [SYM_W-1:0]     sym_q;
  logic [AW-1:0]        tab_cnt_q;
  logic [SW-1:0]        scnt_q;
  logic                 rd_vld_q;
  logic                 ovf_q;
  logic [COUNT_WIDTH-1:0] sum_q;
  logic [COUNT_WIDTH-1:0] cur_q [NUM_STATES];
  logic [COUNT_WIDTH-1:0] nxt_q [NUM_STATES];
  logic                   m_vld_q;
  logic [OUT_DATA_W-1:0]  m_data_q;

  // table memory
  logic [IW-1:0] idx_x;
  logic          idx_ok;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  napc_entry_t   ld_ent;
  napc_entry_t   ent;

  assign idx_x     = IW'(in_idx);
  assign idx_ok    = 32'(in_idx) < 32'(MAX_TRANSITIONS);
  assign ld_ent    = '{valid: in_ev, to: in_to, sym: in_sym, from: in_from};
  assign ram_we    = cmd_i.clr_wr | (cmd_i.load & idx_ok);
  assign ram_waddr = cmd_i.clr_wr ? tab_cnt_q : idx_x[AW-1:0];
  assign ram_wdata = cmd_i.clr_wr ? '0 : ld_ent;

  napc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TRANSITIONS)
  ) u_tab (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (tab_cnt_q),
    .rdata_o (ram_rdata)
  );

  assign ent = napc_entry_t'(ram_rdata);

  // scan step: nxt[to] += cur[from]
  logic [XW-1:0]          from_x;
  logic [XW-1:0]          to_x;
  logic [SW-1:0]          from_idx;
  logic [SW-1:0]          to_idx;
  logic                   hit;
  logic [SW-1:0]          cur_raddr;
  logic [COUNT_WIDTH-1:0] cur_rd;
  logic [COUNT_WIDTH-1:0] nxt_rd;
  logic                   add_c;
  logic [COUNT_WIDTH-1:0] add_s;
  logic [COUNT_WIDTH-1:0] add_res;

  assign from_x   = XW'(ent.from);
  assign to_x     = XW'(ent.to);
  assign from_idx = from_x[SW-1:0];
  assign to_idx   = to_x[SW-1:0];
  assign hit = rd_vld_q && ent.valid && (ent.sym == sym_q)
            && (32'(ent.from) < 32'(NUM_STATES)) && (32'(ent.to) < 32'(NUM_STATES));

  assign cur_raddr = rd_vld_q ? from_idx : scnt_q;
  assign cur_rd    = cur_q[cur_raddr];
  assign nxt_rd    = nxt_q[to_idx];
  assign {add_c, add_s} = {1'b0, nxt_rd} + {1'b0, cur_rd};
  assign add_res = add_c ? '1 : add_s;

  // final-state sum step
  logic [NUM_STATES-1:0]  fmask_n;
  logic                   fsel;
  logic                   sum_c;
  logic [COUNT_WIDTH-1:0] sum_s;

  for (genvar g = 0; g < NUM_STATES; g++) begin : g_fmask
    if (g < 16) begin : g_in
      assign fmask_n[g] = fmask_q[g];
    end else begin : g_out
      assign fmask_n[g] = 1'b0;
    end
  end

  assign fsel = fmask_n[scnt_q];
  assign {sum_c, sum_s} = {1'b0, sum_q} + {1'b0, cur_rd};

  // result formatting
  logic [63:0]         sum_ext;
  logic                clip;
  logic [PCOUNT_W-1:0] pcount;

  assign sum_ext = 64'(sum_q);
  assign clip    = sum_ext > 64'h0000_0000_FFFF_FFFF;
  assign pcount  = clip ? '1 : sum_ext[PCOUNT_W-1:0];

  // start state
  logic [XW-1:0] start_x;
  logic          start_ok;

  assign start_x  = XW'(start_q);
  assign start_ok = 32'(start_q) < 32'(NUM_STATES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= '0;
      fmask_q   <= '0;
      tab_cnt_q <= '0;
      scnt_q    <= '0;
      rd_vld_q  <= 1'b0;
      ovf_q     <= 1'b0;
      m_vld_q   <= 1'b0;
      for (int i = 0; i < NUM_STATES; i++) begin
        cur_q[i] <= '0;
        nxt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_START_STATE: start_q <= cfg_wdata_i[STATE_W-1:0];
          CFG_FINAL_MASK:  fmask_q <= cfg_wdata_i;
          default:         start_q <= start_q;
        endcase
      end

      rd_vld_q <= cmd_i.scan_rd;

      if (cmd_i.sym_begin || cmd_i.fin_begin) begin
        tab_cnt_q <= '0;
        scnt_q    <= '0;
      end else begin
        if (cmd_i.clr_wr || cmd_i.scan_rd) begin
          tab_cnt_q <= tab_cnt_q + 1'b1;
        end
        if (cmd_i.sum_step) begin
          scnt_q <= scnt_q + 1'b1;
        end
      end

      if (cmd_i.start) begin
        for (int i = 0; i < NUM_STATES; i++) begin
          cur_q[i] <= '0;
        end
        if (start_ok) begin
          cur_q[start_x[SW-1:0]] <= COUNT_WIDTH'(1);
        end
      end else if (cmd_i.copy) begin
        for (int i = 0; i < NUM_STATES; i++) begin
          cur_q[i] <= nxt_q[i];
        end
      end

      if (cmd_i.sym_begin) begin
        for (int i = 0; i < NUM_STATES; i++) begin
          nxt_q[i] <= '0;
        end
      end else if (hit) begin
        nxt_q[to_idx] <= add_res;
      end

      if (cmd_i.start) begin
        ovf_q <= 1'b0;
      end else if ((hit && add_c) || (cmd_i.sum_step && fsel && sum_c) ||
                   (cmd_i.emit && clip)) begin
        ovf_q <= 1'b1;
      end

      if (cmd_i.emit) begin
        m_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sym_begin) begin
      sym_q <= in_sym;
    end
    if (cmd_i.fin_begin) begin
      sum_q <= '0;
    end else if (cmd_i.sum_step && fsel) begin
      sum_q <= sum_c ? '1 : sum_s;
    end
    if (cmd_i.emit) begin
      m_data_q <= {6'd0, ovf_q | clip, |sum_q, pcount};
    end
  end

  assign stat_o.tab_last = tab_cnt_q == AW'(MAX_TRANSITIONS - 1);
  assign stat_o.fin_last = scnt_q == SW'(NF - 1);
  assign stat_o.out_free = !m_vld_q || m_tready_i;
  assign m_tvalid_o      = m_vld_q;
  assign m_tdata_o       = m_data_q;

  `NAPC_ASSERT(a_rd_follow, cmd_i.scan_rd |=> rd_vld_q, "table read data not marked valid")
  `NAPC_ASSERT(a_start_clr, cmd_i.start |=> !ovf_q, "start did not clear saturation flag")
  `NAPC_ASSERT(a_emit_vld, cmd_i.emit |=> m_vld_q, "emitted result not presented")
  `NAPC_ASSERT_ALWAYS(a_wr_excl, !(cmd_i.load && cmd_i.clr_wr), "load during clearing pass")

endmodule

`default_nettype wire

// ===== rtl/nfa_accepting_path_counter.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: kind; tdata: entry fields
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: path_count, accepted, saturated
// cfg       in   cfg_we_i                      cfg_idx_i, cfg_wdata_i
//
// Load and start items are handled in the idle state. A symbol item makes one read of
// the transition table per entry, then drain and copy.
// A finish item checks min(NUM_STATES, 16) states for the final mask, one state per cycle.
// After reset a clearing pass writes zero to all MAX_TRANSITIONS table entries; no item
// is accepted meanwhile. A waiting result sits in the output register while further
// items are accepted; a second finish holds until that result is taken.
`default_nettype none

module nfa_accepting_path_counter
  import napc_pkg::*;
#(
  parameter int unsigned NUM_STATES      = 16,
  parameter int unsigned MAX_TRANSITIONS = 64,
  parameter int unsigned COUNT_WIDTH     = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // entry_index[5:0], from_state[9:6], symbol[17:10], to_state[21:18],
  // entry_valid[22], zero[23]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  wire logic [KIND_W-1:0]     s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // path_count[31:0], accepted[32], saturated[33], zero[39:34]
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i
);

  napc_cmd_t  cmd;
  napc_stat_t stat;

  napc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  napc_dp #(
    .NUM_STATES      (NUM_STATES),
    .MAX_TRANSITIONS (MAX_TRANSITIONS),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_nfa_accepting_path_counter.sv =====
`timescale 1ns / 1ps

module tb_nfa_accepting_path_counter;
  import napc_pkg::*;

  localparam int unsigned STATES         = 16;
  localparam int unsigned SLOTS          = 64;
  localparam int unsigned TOTAL_ITEMS    = 1150;
  localparam int unsigned PHASES         = 12;
  localparam int unsigned SETTLE_CYCLES  = 200;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef struct {
    napc_kind_e         kind;
    logic [IDX_W-1:0]   idx;
    logic [STATE_W-1:0] from_st;
    logic [SYM_W-1:0]   sym;
    logic [STATE_W-1:0] to_st;
    logic               ev;
  } nfa_item_t;

  typedef struct {
    logic [PCOUNT_W-1:0] count;
    logic                accepted;
    logic                saturated;
  } tally_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [KIND_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_W-1:0]      cfg_wdata_i   = '0;

  nfa_accepting_path_counter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the automaton: transition table, per-state path counts, sticky clip flag.
  napc_entry_t         trans_tab [SLOTS];
  logic [PCOUNT_W-1:0] state_paths [STATES];
  logic                paths_clipped;
  logic [STATE_W-1:0]  start_sh = '0;
  logic [CFG_W-1:0]    final_sh = '0;

  nfa_item_t   pending_q [$];
  nfa_item_t   in_flight;
  logic        in_busy;
  tally_t      expected_tallies [$];
  tally_t      want;
  int unsigned n_queued      = 0;
  int unsigned n_errors      = 0;
  int unsigned src_idle_pct  = 32;
  int unsigned sink_idle_pct = 52;
  int unsigned hold_req_cnt  = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  function automatic logic [PCOUNT_W-1:0] clip_add(input logic [PCOUNT_W-1:0] a,
                                                   input logic [PCOUNT_W-1:0] b);
    logic [PCOUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[PCOUNT_W]) begin
      paths_clipped = 1'b1;
      return '1;
    end
    return s[PCOUNT_W-1:0];
  endfunction

  task automatic step_path_counts(input nfa_item_t it);
    logic [PCOUNT_W-1:0] nxt [STATES];
    logic [PCOUNT_W-1:0] sum;
    tally_t              t;
    case (it.kind)
      KIND_LOAD: begin
        trans_tab[it.idx].valid = it.ev;
        trans_tab[it.idx].from  = it.from_st;
        trans_tab[it.idx].sym   = it.sym;
        trans_tab[it.idx].to    = it.to_st;
      end
      KIND_START: begin
        foreach (state_paths[i]) state_paths[i] = '0;
        paths_clipped = 1'b0;
        state_paths[start_sh] = 1;
      end
      KIND_SYMBOL: begin
        foreach (nxt[i]) nxt[i] = '0;
        for (int i = 0; i < SLOTS; i++) begin
          if (trans_tab[i].valid && trans_tab[i].sym == it.sym)
            nxt[trans_tab[i].to] = clip_add(nxt[trans_tab[i].to],
                                            state_paths[trans_tab[i].from]);
        end
        state_paths = nxt;
      end
      KIND_FINISH: begin
        sum = '0;
        for (int i = 0; i < STATES; i++) begin
          if (final_sh[i]) sum = clip_add(sum, state_paths[i]);
        end
        t.count     = sum;
        t.accepted  = (sum != 0);
        t.saturated = paths_clipped;
        expected_tallies.push_back(t);
      end
      default: ;
    endcase
  endtask

  // Sender: offer pending items, hold each until the transaction completes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) trans_tab[i] = '0;
      foreach (state_paths[i]) state_paths[i] = '0;
      paths_clipped = 1'b0;
    end else begin
      in_busy = s_axis_tvalid && !s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) step_path_counts(in_flight);
      if (!in_busy) begin
        if (pending_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
          in_flight = pending_q.pop_front();
          s_axis_tuser  <= in_flight.kind;
          s_axis_tdata  <= {1'b0, in_flight.ev, in_flight.to_st, in_flight.sym,
                            in_flight.from_st, in_flight.idx};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result against the oldest expected tally.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_tallies.size() == 0) begin
          $display("%0t: unexpected result, expected none, got count %0d acc %0b sat %0b",
                   $time, m_axis_tdata[PCOUNT_W-1:0], m_axis_tdata[PCOUNT_W],
                   m_axis_tdata[PCOUNT_W+1]);
          n_errors++;
        end else begin
          want = expected_tallies.pop_front();
          if (m_axis_tdata[PCOUNT_W-1:0] !== want.count) begin
            $display("%0t: path_count expected %0d got %0d", $time, want.count,
                     m_axis_tdata[PCOUNT_W-1:0]);
            n_errors++;
          end
          if (m_axis_tdata[PCOUNT_W] !== want.accepted) begin
            $display("%0t: accepted expected %0b got %0b", $time, want.accepted,
                     m_axis_tdata[PCOUNT_W]);
            n_errors++;
          end
          if (m_axis_tdata[PCOUNT_W+1] !== want.saturated) begin
            $display("%0t: saturated expected %0b got %0b", $time, want.saturated,
                     m_axis_tdata[PCOUNT_W+1]);
            n_errors++;
          end
        end
      end
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_item(input napc_kind_e k, input logic [IDX_W-1:0] idx,
                            input logic [STATE_W-1:0] fr, input logic [SYM_W-1:0] sy,
                            input logic [STATE_W-1:0] to, input logic ev);
    nfa_item_t it;
    it.kind    = k;
    it.idx     = idx;
    it.from_st = fr;
    it.sym     = sy;
    it.to_st   = to;
    it.ev      = ev;
    pending_q.push_back(it);
    n_queued++;
  endtask

  // Start, symbol and finish items carry random filler in the index, state and valid fields.
  task automatic queue_ctl(input napc_kind_e k, input logic [SYM_W-1:0] sy);
    queue_item(k, IDX_W'($urandom_range(63, 0)), STATE_W'($urandom_range(15, 0)), sy,
               STATE_W'($urandom_range(15, 0)), 1'($urandom_range(1, 0)));
  endtask

  // One string: load over a small alphabet, start, symbols, finish; or random items.
  task automatic queue_session();
    logic [SYM_W-1:0] base;
    int unsigned      mode, asz, n_load, len;
    mode = $urandom_range(99, 0);
    if (mode < 15) begin
      repeat ($urandom_range(6, 1))
        queue_item(napc_kind_e'($urandom_range(3, 0)), IDX_W'($urandom_range(63, 0)),
                   STATE_W'($urandom_range(15, 0)), SYM_W'($urandom_range(255, 0)),
                   STATE_W'($urandom_range(15, 0)), 1'($urandom_range(1, 0)));
      return;
    end
    base = SYM_W'($urandom_range(255, 0));
    if (mode < 30) begin
      // dense table on one symbol: counts grow fast enough to clip
      asz    = 1;
      n_load = $urandom_range(40, 24);
      len    = $urandom_range(34, 20);
    end else begin
      asz    = $urandom_range(4, 1);
      n_load = $urandom_range(10, 0);
      len    = (mode < 35) ? 0 : $urandom_range(12, 1);
    end
    repeat (n_load)
      queue_item(KIND_LOAD, IDX_W'($urandom_range(63, 0)), STATE_W'($urandom_range(15, 0)),
                 base ^ SYM_W'($urandom_range(asz - 1, 0)), STATE_W'($urandom_range(15, 0)),
                 $urandom_range(9, 0) != 0);
    queue_ctl(KIND_START, SYM_W'($urandom_range(255, 0)));
    repeat (len) begin
      if ($urandom_range(19, 0) == 0)
        queue_ctl(KIND_SYMBOL, SYM_W'($urandom_range(255, 0)));
      else
        queue_ctl(KIND_SYMBOL, base ^ SYM_W'($urandom_range(asz - 1, 0)));
      if ($urandom_range(7, 0) == 0) queue_ctl(KIND_FINISH, SYM_W'($urandom_range(255, 0)));
    end
    queue_ctl(KIND_FINISH, SYM_W'($urandom_range(255, 0)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_START_STATE) start_sh = val[STATE_W-1:0];
    else final_sh = val;
  endtask

  // Wait until every item is taken and every result is in, then let a symbol scan finish.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || expected_tallies.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int unsigned        phase_end;
    logic [STATE_W-1:0] start_v;
    logic [CFG_W-1:0]   mask_v;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers still at reset: no final state, counts all zero.
    @(negedge clk_i);
    queue_ctl(KIND_FINISH, 8'h00);
    queue_ctl(KIND_SYMBOL, 8'hFF);
    wait_quiet();
    write_reg(CFG_START_STATE, 16'h0000);
    write_reg(CFG_FINAL_MASK, 16'hFFFF);

    @(negedge clk_i);
    queue_item(KIND_LOAD, 6'd0, 4'd0, 8'h00, 4'd1, 1'b1);
    queue_item(KIND_LOAD, 6'd1, 4'd0, 8'h00, 4'd1, 1'b1);  // duplicate entry
    queue_item(KIND_LOAD, 6'd2, 4'd1, 8'hFF, 4'd15, 1'b1);
    queue_item(KIND_LOAD, 6'd63, 4'd15, 8'hFF, 4'd15, 1'b1);
    queue_ctl(KIND_START, 8'h3C);
    queue_ctl(KIND_FINISH, 8'hC3);  // empty string
    queue_ctl(KIND_SYMBOL, 8'h00);
    queue_ctl(KIND_FINISH, 8'h00);
    queue_ctl(KIND_SYMBOL, 8'hFF);
    queue_ctl(KIND_SYMBOL, 8'hFF);
    queue_ctl(KIND_FINISH, 8'hFF);  // counts survive the previous finish
    queue_item(KIND_LOAD, 6'd1, 4'd15, 8'hFF, 4'd0, 1'b0);  // clear the duplicate
    queue_ctl(KIND_START, 8'h00);
    queue_ctl(KIND_SYMBOL, 8'h00);
    queue_ctl(KIND_FINISH, 8'h00);
    queue_ctl(KIND_SYMBOL, 8'h5A);  // no matching entry
    queue_ctl(KIND_FINISH, 8'hA5);
    wait_quiet();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 4) begin
        src_idle_pct  = 52;
        sink_idle_pct = 32;
      end else if (p == 8) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      start_v = STATE_W'($urandom_range(15, 0));
      mask_v  = CFG_W'($urandom_range(16'hFFFF, 0));
      if (p == 0) begin
        start_v = 4'd15;
        mask_v  = 16'hFFFF;
      end else if (p == 1) begin
        start_v = 4'd0;
        mask_v  = 16'h0001;
      end else if (p == 2) begin
        mask_v  = 16'h0000;
      end else if (p == 3) begin
        mask_v  = 16'h8000;
      end
      write_reg(CFG_START_STATE, {12'($urandom), start_v});
      write_reg(CFG_FINAL_MASK, mask_v);
      @(negedge clk_i);
      if (p == 5 || p == 10) begin
        // stall the receiver and pile up finishes so the input backs up
        hold_req_cnt++;
        queue_ctl(KIND_START, SYM_W'($urandom_range(255, 0)));
        repeat (4) queue_ctl(KIND_FINISH, SYM_W'($urandom_range(255, 0)));
      end
      phase_end = n_queued + (TOTAL_ITEMS - n_queued) / (PHASES - p);
      while (n_queued < phase_end) queue_session();
      wait_quiet();
    end

    n_errors += expected_tallies.size();
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
